// ===== src/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared widths, codes, request types and the saturating sum add.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF = 1024;

  localparam int unsigned CNT_W    = 11;
  localparam int unsigned VIDX_W   = 10;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned LIM_W    = 17;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned EDGE_W   = 17;
  localparam int unsigned PROD_W   = 34;
  localparam int unsigned FACE_W   = 35;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned NRM_W    = 16;
  localparam int unsigned ST_W     = 2;

  localparam int unsigned MAG_W    = 31;
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned DIV_W    = MAG_W + FRAC_W;
  localparam int unsigned QUO_W    = FRAC_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               oor;
    logic [IDX_W-1:0]   vidx;
    logic [IDX_W-1:0]   corner_a;
    logic [IDX_W-1:0]   corner_b;
    logic [IDX_W-1:0]   corner_c;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
  } cmd_t;

  typedef struct packed {
    logic [NRM_W-1:0] x;
    logic [NRM_W-1:0] y;
    logic [NRM_W-1:0] z;
    logic [ST_W-1:0]  status;
  } norm_res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [FACE_W-1:0] f);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W + 1 - FACE_W){f[FACE_W-1]}}, f};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ===== src/vna_ram.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vna_front.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Takes requests, checks ranges, drops no-ops and queues work for the back end.
// ----------------------------------------------------------------------------
module vna_front #(
  parameter int unsigned VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vna_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [vna_pkg::VIDX_W-1:0] vertex_index_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_x_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_y_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_z_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_a_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_c_i,
  input  logic                       busy_i,
  output logic                       cmd_valid_o,
  output vna_pkg::cmd_t              cmd_o,
  input  logic                       cmd_pop_i
);
  import vna_pkg::*;

  localparam logic [LIM_W-1:0] DepthC = LIM_W'(VERTEX_DEPTH);

  logic [CNT_W-1:0]  vcount_q;
  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept, push, full;
  logic [LIM_W-1:0]  lim, vc_w;
  cmd_t              cmd;

  assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign in_stall_o = full | busy_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vc_w       = LIM_W'(vcount_q);
  assign lim        = (vc_w < DepthC) ? vc_w : DepthC;

  always_comb begin
    push         = 1'b0;
    cmd.kind     = CMD_LOAD;
    cmd.oor      = 1'b0;
    cmd.vidx     = IDX_W'(vertex_index_i);
    cmd.corner_a = corner_a_i;
    cmd.corner_b = corner_b_i;
    cmd.corner_c = corner_c_i;
    cmd.pos_x    = pos_x_i;
    cmd.pos_y    = pos_y_i;
    cmd.pos_z    = pos_z_i;
    unique case (op_e'(op_i))
      OP_LOAD: begin
        cmd.kind = CMD_LOAD;
        push     = accept & (LIM_W'(vertex_index_i) < DepthC);
      end
      OP_TRI: begin
        cmd.kind = CMD_TRI;
        push     = accept & (LIM_W'(corner_a_i) < lim) & (LIM_W'(corner_b_i) < lim)
                   & (LIM_W'(corner_c_i) < lim);
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
        cmd.oor  = (LIM_W'(vertex_index_i) >= lim);
        push     = accept;
      end
      OP_NOP: push = 1'b0;
      default: push = 1'b0;
    endcase
  end

  assign cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(cmd_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

endmodule

// ===== src/vna_norm.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator normalizer
// Scales a 48-bit sum vector to a Q1.14 unit vector: shift, square, root, divide.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vna_pkg::SUM_W-1:0] sum_x_i,
  input  logic [vna_pkg::SUM_W-1:0] sum_y_i,
  input  logic [vna_pkg::SUM_W-1:0] sum_z_i,
  output logic                      done_o,
  output vna_pkg::norm_res_t        res_o
);
  import vna_pkg::*;

  localparam logic [3:0] N_IDLE  = 4'd0;
  localparam logic [3:0] N_CHECK = 4'd1;
  localparam logic [3:0] N_SHIFT = 4'd2;
  localparam logic [3:0] N_SQ    = 4'd3;
  localparam logic [3:0] N_ACC   = 4'd4;
  localparam logic [3:0] N_ROOT  = 4'd5;
  localparam logic [3:0] N_DIVI  = 4'd6;
  localparam logic [3:0] N_DIV   = 4'd7;
  localparam logic [3:0] N_SIGN  = 4'd8;
  localparam logic [3:0] N_DONE  = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [SUM_W-1:0]   m_q [3];
  logic [2:0]         neg_q;
  logic [1:0]         k_q;
  logic [4:0]         cnt_q;
  logic [2*MAG_W-1:0] prod_q;
  logic [SQ_W-1:0]    sq_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [DIV_W:0]     drem_q, div_q;
  logic [QUO_W-1:0]   quo_q;
  logic [NRM_W-1:0]   res_q [3];
  logic [ST_W-1:0]    status_q;
  logic [SUM_W-1:0]   mor;
  logic [REM_W+1:0]   rem_sh, trial;

  assign mor    = m_q[0] | m_q[1] | m_q[2];
  assign rem_sh = {rem_q, sq_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (start_i) state_d = N_CHECK;
      N_CHECK: state_d = (mor == '0) ? N_DONE : N_SHIFT;
      N_SHIFT: if (mor[SUM_W-1:MAG_W] == '0) state_d = N_SQ;
      N_SQ:    state_d = N_ACC;
      N_ACC:   state_d = (k_q == 2'd2) ? N_ROOT : N_SQ;
      N_ROOT:  if (cnt_q == 5'd31) state_d = N_DIVI;
      N_DIVI:  state_d = N_DIV;
      N_DIV:   if (cnt_q == 5'(QUO_W - 1)) state_d = N_SIGN;
      N_SIGN:  state_d = (k_q == 2'd2) ? N_DONE : N_DIVI;
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        m_q[0] <= sum_x_i[SUM_W-1] ? (~sum_x_i + 1'b1) : sum_x_i;
        m_q[1] <= sum_y_i[SUM_W-1] ? (~sum_y_i + 1'b1) : sum_y_i;
        m_q[2] <= sum_z_i[SUM_W-1] ? (~sum_z_i + 1'b1) : sum_z_i;
        neg_q  <= {sum_z_i[SUM_W-1], sum_y_i[SUM_W-1], sum_x_i[SUM_W-1]};
      end
      N_CHECK: begin
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
        status_q <= (mor == '0) ? ST_ZERO : ST_OK;
      end
      N_SHIFT: begin
        if (mor[SUM_W-1:MAG_W] != '0) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end else begin
          k_q  <= 2'd0;
          sq_q <= '0;
        end
      end
      N_SQ: prod_q <= m_q[k_q][MAG_W-1:0] * m_q[k_q][MAG_W-1:0];
      N_ACC: begin
        sq_q <= sq_q + SQ_W'(prod_q);
        if (k_q == 2'd2) begin
          cnt_q  <= '0;
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      N_ROOT: begin
        sq_q  <= sq_q << 2;
        cnt_q <= cnt_q + 5'd1;
        k_q   <= 2'd0;
        if (rem_sh >= trial) begin
          rem_q  <= REM_W'(rem_sh - trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= REM_W'(rem_sh);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      N_DIVI: begin
        drem_q <= (DIV_W + 1)'({m_q[k_q][MAG_W-1:0], {FRAC_W{1'b0}}})
                  + (DIV_W + 1)'(root_q[ROOT_W-1:1]);
        div_q  <= (DIV_W + 1)'({root_q, {FRAC_W{1'b0}}});
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      N_DIV: begin
        div_q <= div_q >> 1;
        cnt_q <= cnt_q + 5'd1;
        if (drem_q >= div_q) begin
          drem_q <= drem_q - div_q;
          quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      N_SIGN: begin
        res_q[k_q] <= neg_q[k_q] ? (~NRM_W'(quo_q) + 1'b1) : NRM_W'(quo_q);
        k_q        <= k_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign done_o       = (state_q == N_DONE);
  assign res_o.x      = res_q[0];
  assign res_o.y      = res_q[1];
  assign res_o.z      = res_q[2];
  assign res_o.status = status_q;

endmodule

// ===== src/vna_back.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Owns position and sum RAMs, runs loads, triangle updates and reads.
// ----------------------------------------------------------------------------
module vna_back #(
  parameter int unsigned VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  vna_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      clearing_o,
  output logic                      norm_start_o,
  output logic [vna_pkg::SUM_W-1:0] norm_sum_x_o,
  output logic [vna_pkg::SUM_W-1:0] norm_sum_y_o,
  output logic [vna_pkg::SUM_W-1:0] norm_sum_z_o,
  input  logic                      norm_done_i,
  input  vna_pkg::norm_res_t        norm_res_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic [vna_pkg::NRM_W-1:0] normal_z_o,
  output logic [vna_pkg::ST_W-1:0]  read_status_o
);
  import vna_pkg::*;

  localparam int unsigned AW = $clog2(VERTEX_DEPTH);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_TP1  = 4'd2;
  localparam logic [3:0] S_TP2  = 4'd3;
  localparam logic [3:0] S_TP3  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_SUB  = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SWR  = 4'd8;
  localparam logic [3:0] S_RDAT = 4'd9;
  localparam logic [3:0] S_NORM = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]           state_q, state_d;
  logic [AW-1:0]        clr_cnt_q;
  cmd_t                 cmd_q;
  logic [3*POS_W-1:0]   p0_q, p1_q;
  logic [EDGE_W-1:0]    e1_q [3];
  logic [EDGE_W-1:0]    e2_q [3];
  logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
  logic [FACE_W-1:0]    f_q [3];
  logic [1:0]           k_q, j_q;
  norm_res_t            res_q, out_q;
  logic                 out_valid_q, out_valid_d, out_load, out_free;

  logic                 pos_we, sum_we;
  logic [AW-1:0]        pos_waddr, pos_raddr, sum_waddr, sum_raddr, corner_j;
  logic [3*POS_W-1:0]   pos_wdata, pos_rdata;
  logic [3*SUM_W-1:0]   sum_wdata, sum_rdata;
  logic signed [EDGE_W-1:0] ma, mb, mc, md;

  vna_ram #(.WIDTH(3 * POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.WIDTH(3 * SUM_W), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  always_comb begin
    case (j_q)
      2'd0:    corner_j = cmd_q.corner_a[AW-1:0];
      2'd1:    corner_j = cmd_q.corner_b[AW-1:0];
      default: corner_j = cmd_q.corner_c[AW-1:0];
    endcase
  end

  always_comb begin
    case (k_q)
      2'd0: begin
        ma = e1_q[1]; mb = e2_q[2]; mc = e1_q[2]; md = e2_q[1];
      end
      2'd1: begin
        ma = e1_q[2]; mb = e2_q[0]; mc = e1_q[0]; md = e2_q[2];
      end
      default: begin
        ma = e1_q[0]; mb = e2_q[1]; mc = e1_q[1]; md = e2_q[0];
      end
    endcase
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_pop_o    = 1'b0;
    pos_we       = 1'b0;
    pos_waddr    = cmd_i.vidx[AW-1:0];
    pos_wdata    = {cmd_i.pos_z, cmd_i.pos_y, cmd_i.pos_x};
    pos_raddr    = cmd_i.corner_a[AW-1:0];
    sum_we       = 1'b0;
    sum_waddr    = cmd_i.vidx[AW-1:0];
    sum_wdata    = '0;
    sum_raddr    = cmd_i.vidx[AW-1:0];
    norm_start_o = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_CLR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_cnt_q;
        if (clr_cnt_q == AW'(VERTEX_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD: begin
              pos_we = 1'b1;
              sum_we = 1'b1;
            end
            CMD_TRI:  state_d = S_TP1;
            CMD_READ: state_d = cmd_i.oor ? S_OUT : S_RDAT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_TP1: begin
        pos_raddr = cmd_q.corner_b[AW-1:0];
        state_d   = S_TP2;
      end
      S_TP2: begin
        pos_raddr = cmd_q.corner_c[AW-1:0];
        state_d   = S_TP3;
      end
      S_TP3: state_d = S_MUL;
      S_MUL: state_d = S_SUB;
      S_SUB: state_d = (k_q == 2'd2) ? S_SRD : S_MUL;
      S_SRD: begin
        sum_raddr = corner_j;
        state_d   = S_SWR;
      end
      S_SWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_j;
        sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], f_q[2]),
                     sat_add(sum_rdata[2*SUM_W-1:SUM_W], f_q[1]),
                     sat_add(sum_rdata[SUM_W-1:0], f_q[0])};
        state_d   = (j_q == 2'd2) ? S_IDLE : S_SRD;
      end
      S_RDAT: begin
        norm_start_o = 1'b1;
        state_d      = S_NORM;
      end
      S_NORM: if (norm_done_i) state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
      res_q <= '{x: '0, y: '0, z: '0, status: ST_RANGE};
    end
    case (state_q)
      S_TP1: p0_q <= pos_rdata;
      S_TP2: p1_q <= pos_rdata;
      S_TP3: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EDGE_W'($signed(p1_q[i*POS_W +: POS_W]))
                     - EDGE_W'($signed(p0_q[i*POS_W +: POS_W]));
          e2_q[i] <= EDGE_W'($signed(pos_rdata[i*POS_W +: POS_W]))
                     - EDGE_W'($signed(p0_q[i*POS_W +: POS_W]));
        end
        k_q <= 2'd0;
      end
      S_MUL: begin
        prod_a_q <= ma * mb;
        prod_b_q <= mc * md;
      end
      S_SUB: begin
        f_q[k_q] <= FACE_W'(prod_a_q) - FACE_W'(prod_b_q);
        k_q      <= k_q + 2'd1;
        j_q      <= 2'd0;
      end
      S_SWR: j_q <= j_q + 2'd1;
      S_NORM: if (norm_done_i) res_q <= norm_res_i;
      default: ;
    endcase
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign norm_sum_x_o  = sum_rdata[SUM_W-1:0];
  assign norm_sum_y_o  = sum_rdata[2*SUM_W-1:SUM_W];
  assign norm_sum_z_o  = sum_rdata[3*SUM_W-1:2*SUM_W];
  assign clearing_o    = (state_q == S_CLR);
  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = out_q.x;
  assign normal_y_o    = out_q.y;
  assign normal_z_o    = out_q.z;
  assign read_status_o = out_q.status;

endmodule

// ===== src/vertex_normal_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator unit
// Area-weighted vertex normals: position store, saturating per-vertex sums,
// Q1.14 normalized read-out.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we_i               cfg_wdata_i (vertex count)
//   in        in         in_valid_i/in_stall_o  op, index, position, corners
//   out       out        out_valid_o/out_stall_i normal x/y/z, read status
//
// Load: handled by the back end from its idle state. Triangle: queue pop, 3 position
// RAM reads, cross product on two 17x17 multipliers, read-modify-write of each corner's sums.
// Read: runs the normalizer (up to 17 shifts, 32-step root, 3 x 15-step divide);
// an out-of-range read skips it. After reset a clearing pass zeroes the sum RAM
// while in_stall_o is high. A two-deep request queue and the output register let
// input and output stall independently.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit #(
  parameter int unsigned VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vna_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [vna_pkg::VIDX_W-1:0] vertex_index_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_x_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_y_i,
  input  logic [vna_pkg::POS_W-1:0]  pos_z_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_a_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]  corner_c_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [vna_pkg::NRM_W-1:0]  normal_x_o,
  output logic [vna_pkg::NRM_W-1:0]  normal_y_o,
  output logic [vna_pkg::NRM_W-1:0]  normal_z_o,
  output logic [vna_pkg::ST_W-1:0]   read_status_o
);
  import vna_pkg::*;

  logic             clearing, cmd_valid, cmd_pop, norm_start, norm_done;
  cmd_t             cmd;
  logic [SUM_W-1:0] nsum_x, nsum_y, nsum_z;
  norm_res_t        norm_res;

  vna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .corner_a_i     (corner_a_i),
    .corner_b_i     (corner_b_i),
    .corner_c_i     (corner_c_i),
    .busy_i         (clearing),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  vna_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sum_x_i (nsum_x),
    .sum_y_i (nsum_y),
    .sum_z_i (nsum_z),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  vna_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .clearing_o    (clearing),
    .norm_start_o  (norm_start),
    .norm_sum_x_o  (nsum_x),
    .norm_sum_y_o  (nsum_y),
    .norm_sum_z_o  (nsum_z),
    .norm_done_i   (norm_done),
    .norm_res_i    (norm_res),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .read_status_o (read_status_o)
  );

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("request accepted during sum clearing");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !cmd_pop)
    else $error("queue popped during sum clearing");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_status_o != ST_OK) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("nonzero normal with error status");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_status_o == ST_OK) |->
      ($signed(normal_x_o) >= -16384 && $signed(normal_x_o) <= 16384 &&
       $signed(normal_y_o) >= -16384 && $signed(normal_y_o) <= 16384 &&
       $signed(normal_z_o) >= -16384 && $signed(normal_z_o) <= 16384))
    else $error("normal component out of Q1.14 unit range");

endmodule

// ===== tb/sv/vertex_normal_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator unit testbench
// Drives load, triangle, read and no-op requests through the valid/stall
// channel under random idling and output stalls, over several vertex counts.
// A behavioral predictor keeps its own position store and saturating sums and
// computes the expected Q1.14 normal of reads that list none; every read is checked in order.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit_tb;
  import vna_pkg::*;

  localparam int unsigned DEPTH = VERTEX_DEPTH_DEF;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned PHASE_ITEMS = 180;

  typedef struct packed {
    logic             wcfg;
    op_e              op;
    logic [15:0]      vidx;
    logic [POS_W-1:0] px, py, pz;
    logic [IDX_W-1:0] ca, cb, cc;
    logic             chk;
    norm_res_t        exp;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i = OP_NOP;
  logic [VIDX_W-1:0]   vertex_index_i = '0;
  logic [POS_W-1:0]    pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [IDX_W-1:0]    corner_a_i = '0, corner_b_i = '0, corner_c_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [NRM_W-1:0]    normal_x_o, normal_y_o, normal_z_o;
  logic [ST_W-1:0]     read_status_o;

  vertex_normal_accumulator_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .op_i, .vertex_index_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .corner_a_i, .corner_b_i, .corner_c_i, .out_valid_o, .out_stall_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .read_status_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [POS_W-1:0] pos_st [DEPTH][3];
  longint                  sum_st [DEPTH][3];
  bit                      loaded [DEPTH];
  int unsigned             vcount;
  norm_res_t               normals_due [$];
  int unsigned             errors = 0;
  int unsigned             cycles = 0;
  bit                      quiet = 1'b0;

  function automatic int unsigned vlimit();
    return (vcount < DEPTH) ? vcount : DEPTH;
  endfunction

  function automatic longint sat48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic norm_res_t unit_normal(int unsigned v);
    norm_res_t r;
    longint unsigned m[3], mx, sq, len, q;
    logic [NRM_W-1:0] o[3];
    r = '0;
    if (v >= vlimit()) begin
      r.status = ST_RANGE;
      return r;
    end
    for (int i = 0; i < 3; i++)
      m[i] = (sum_st[v][i] < 0) ? longint'(-sum_st[v][i]) : longint'(sum_st[v][i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      if (sum_st[v][i] < 0) q = -q;
      o[i] = q[NRM_W-1:0];
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void accumulate_face(int unsigned a, int unsigned b, int unsigned c);
    longint e1[3], e2[3], f[3];
    int unsigned k[3];
    k = '{a, b, c};
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(pos_st[b][i]) - longint'(pos_st[a][i]);
      e2[i] = longint'(pos_st[c][i]) - longint'(pos_st[a][i]);
    end
    f[0] = e1[1] * e2[2] - e1[2] * e2[1];
    f[1] = e1[2] * e2[0] - e1[0] * e2[2];
    f[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) sum_st[k[j]][i] = sat48(sum_st[k[j]][i], f[i]);
  endfunction

  function automatic void predict_request(stim_row_t r);
    int unsigned lim;
    lim = vlimit();
    case (r.op)
      OP_LOAD: begin
        pos_st[r.vidx[VIDX_W-1:0]] = '{r.px, r.py, r.pz};
        sum_st[r.vidx[VIDX_W-1:0]] = '{0, 0, 0};
        loaded[r.vidx[VIDX_W-1:0]] = 1'b1;
      end
      OP_TRI: begin
        if (r.ca < lim && r.cb < lim && r.cc < lim) accumulate_face(r.ca, r.cb, r.cc);
      end
      OP_READ: begin
        normals_due.push_back(r.chk ? r.exp : unit_normal(r.vidx[VIDX_W-1:0]));
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t ld(int i, int x, int y, int z);
    stim_row_t r;
    r = '0;
    r.op = OP_LOAD;
    r.vidx = 16'(i);
    r.px = POS_W'(x);
    r.py = POS_W'(y);
    r.pz = POS_W'(z);
    return r;
  endfunction

  function automatic stim_row_t face(int a, int b, int c);
    stim_row_t r;
    r = '0;
    r.op = OP_TRI;
    r.ca = IDX_W'(a);
    r.cb = IDX_W'(b);
    r.cc = IDX_W'(c);
    return r;
  endfunction

  function automatic stim_row_t rd(int i);
    stim_row_t r;
    r = '0;
    r.op = OP_READ;
    r.vidx = 16'(i);
    return r;
  endfunction

  function automatic stim_row_t rdx(int i, int x, int y, int z, logic [ST_W-1:0] st);
    stim_row_t r;
    r = rd(i);
    r.chk = 1'b1;
    r.exp = '{x: NRM_W'(x), y: NRM_W'(y), z: NRM_W'(z), status: st};
    return r;
  endfunction

  function automatic stim_row_t cf(int v);
    stim_row_t r;
    r = '0;
    r.wcfg = 1'b1;
    r.op = OP_NOP;
    r.vidx = 16'(v);
    return r;
  endfunction

  function automatic stim_row_t nop_req();
    stim_row_t r;
    r = '0;
    r.op = OP_NOP;
    r.vidx = 16'h03FF;
    r.ca = 16'hFFFF;
    return r;
  endfunction

  stim_row_t directed_tab [] = '{
    rdx(0, 0, 0, 0, ST_RANGE),
    face(0, 0, 0),
    cf(1024),
    rdx(1023, 0, 0, 0, ST_ZERO),
    ld(0, 0, 0, 0),
    ld(1, 256, 0, 0),
    ld(2, 0, 256, 0),
    face(0, 1, 2),
    rdx(0, 0, 0, 16384, ST_OK),
    rdx(1, 0, 0, 16384, ST_OK),
    face(0, 2, 1),
    rdx(2, 0, 0, 0, ST_ZERO),
    ld(3, -32768, -32768, -32768),
    ld(4, 32767, 32767, -32768),
    ld(5, 32767, -32768, 32767),
    face(3, 4, 5),
    face(4, 3, 4),
    rd(3),
    rd(4),
    face(0, 1, 1024),
    face(65535, 65535, 65535),
    nop_req(),
    ld(1023, -1, 1, -256),
    cf(1),
    rdx(1, 0, 0, 0, ST_RANGE),
    rd(0)
  };

  task automatic write_vertex_count(int unsigned v);
    in_valid_i <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = v;
  endtask

  task automatic send_request(stim_row_t r);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= r.op;
    vertex_index_i <= r.vidx[VIDX_W-1:0];
    pos_x_i <= r.px;
    pos_y_i <= r.py;
    pos_z_i <= r.pz;
    corner_a_i <= r.ca;
    corner_b_i <= r.cb;
    corner_c_i <= r.cc;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(r);
  endtask

  function automatic int unsigned pick_loaded(int unsigned lim);
    int unsigned v;
    for (int t = 0; t < 12; t++) begin
      v = $urandom_range(lim - 1);
      if (loaded[v]) return v;
    end
    return 65535;
  endfunction

  function automatic stim_row_t random_request();
    stim_row_t r;
    int unsigned lim, sel, span;
    lim = vlimit();
    span = (lim + 3 > DEPTH - 1) ? DEPTH - 1 : lim + 3;
    sel = $urandom_range(99);
    r = '0;
    r.px = POS_W'($urandom);
    r.py = POS_W'($urandom);
    r.pz = POS_W'($urandom);
    r.ca = IDX_W'($urandom);
    r.cb = IDX_W'($urandom);
    r.cc = IDX_W'($urandom);
    r.vidx = 16'(($urandom_range(9) == 0) ? $urandom_range(DEPTH - 1)
                                           : $urandom_range(span));
    if (sel < 30) begin
      r.op = OP_LOAD;
    end else if (sel < 65) begin
      r.op = OP_TRI;
      if (lim != 0 && $urandom_range(99) < 80) begin
        r.ca = IDX_W'(pick_loaded(lim));
        r.cb = IDX_W'(pick_loaded(lim));
        r.cc = ($urandom_range(9) == 0) ? r.ca : IDX_W'(pick_loaded(lim));
      end else if ($urandom_range(1) == 0) begin
        r.ca = IDX_W'(lim + $urandom_range(3));
      end
      if (r.ca < lim && r.cb < lim && r.cc < lim &&
          !(loaded[r.ca] && loaded[r.cb] && loaded[r.cc]))
        r.ca = 16'hFFFF;
    end else if (sel < 97) begin
      r.op = OP_READ;
    end else begin
      r.op = OP_NOP;
    end
    return r;
  endfunction

  int unsigned phase_counts [5] = '{1024, 16, 3, 1000, 1};

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      pos_st[i] = '{0, 0, 0};
      sum_st[i] = '{0, 0, 0};
      loaded[i] = 1'b0;
    end
    vcount = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_tab[i]) begin
      if (directed_tab[i].wcfg) write_vertex_count(32'(directed_tab[i].vidx));
      else send_request(directed_tab[i]);
    end
    foreach (phase_counts[p]) begin
      write_vertex_count(phase_counts[p]);
      quiet = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("vertex_normal_accumulator_unit_tb: clean");
    else $display("vertex_normal_accumulator_unit_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    norm_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normals_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%h y=%h z=%h st=%0d", $time,
                 normal_x_o, normal_y_o, normal_z_o, read_status_o);
      end else begin
        want = normals_due.pop_front();
        if (normal_x_o !== want.x) begin
          errors++;
          $display("%0t: normal_x exp %h got %h", $time, want.x, normal_x_o);
        end
        if (normal_y_o !== want.y) begin
          errors++;
          $display("%0t: normal_y exp %h got %h", $time, want.y, normal_y_o);
        end
        if (normal_z_o !== want.z) begin
          errors++;
          $display("%0t: normal_z exp %h got %h", $time, want.z, normal_z_o);
        end
        if (read_status_o !== want.status) begin
          errors++;
          $display("%0t: read_status exp %0d got %0d", $time, want.status, read_status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("vertex_normal_accumulator_unit_tb: errors");
      $finish;
    end
  end

endmodule
